FILE: src/chtl_pkg.sv
// ----------------------------------------------------------------------------
// chtl_pkg
// Shared field widths and modulo unit constants for the chained hash table.
// ----------------------------------------------------------------------------
package chtl_pkg;

    localparam int KEY_W     = 31;
    localparam int BUCKET_W  = 4;
    localparam int PROBE_W   = 11;

    // modulo unit retires this many key bits per cycle
    localparam int MOD_DIGIT = 4;
    localparam int MOD_STEPS = (KEY_W + MOD_DIGIT - 1) / MOD_DIGIT;
    localparam int MOD_PAD_W = MOD_STEPS * MOD_DIGIT;
    localparam int STEP_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

endpackage

FILE: src/chtl_ram.sv
// ----------------------------------------------------------------------------
// chtl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module chtl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/chtl_mod_unit.sv
// ----------------------------------------------------------------------------
// chtl_mod_unit
// Iterative key modulo bucket count, restoring compare and subtract over a
// few key bits per cycle.
// ----------------------------------------------------------------------------
module chtl_mod_unit
    import chtl_pkg::*;
#(
    parameter int BUCKETS = 11,
    localparam int REM_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    output logic             done,
    output logic [REM_W-1:0] rem
);

    localparam int T_W = REM_W + 1;
    localparam logic [T_W-1:0] DIVISOR = T_W'(BUCKETS);

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [STEP_W-1:0]    step_reg,  step_next;
    logic [MOD_PAD_W-1:0] div_reg,   div_next;
    logic [REM_W-1:0]     rem_reg,   rem_next;

    always_comb
    begin
        logic [REM_W-1:0] r;
        logic [T_W-1:0]   t;
        r = rem_reg;
        for (int i = 0; i < MOD_DIGIT; i++)
        begin
            t = {r, div_reg[MOD_PAD_W-1-i]};
            if (t >= DIVISOR)
            begin
                t = t - DIVISOR;
            end
            r = t[REM_W-1:0];
        end

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;

        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            div_next  = MOD_PAD_W'(key);
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = r;
            div_next  = div_reg << MOD_DIGIT;
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(MOD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            div_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            div_reg  <= div_next;
            rem_reg  <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: src/chained_hash_table_lookup_insert_core.sv
// ----------------------------------------------------------------------------
// chained_hash_table_lookup_insert_core
// Separate chaining hash table with head insertion and lookup-or-insert.
// Each transfer on the input carries a kind and a key; the bucket is key
// modulo BUCKETS, worked out four key bits per cycle. An insert, or a lookup
// that misses, links a fresh pool node at the head of the bucket's chain, or
// flags pool_full once all POOL_NODES nodes are in use. A lookup walks the
// chain with one node memory read per node. ST_IDLE takes the key and starts
// the modulo unit, ST_MOD reads the bucket head and ST_HWAIT takes it; a
// lookup then walks the chain in ST_NODE and ST_NWAIT, giving a hit from
// ST_NWAIT, and an insert or a miss ends in ST_INSERT. One item is in work
// at a time; a new item is taken only while the output register is empty
// or its result is being taken. After reset the bucket head table
// is cleared in ST_CLEAR, during which no input transfer is taken.
// ----------------------------------------------------------------------------
module chained_hash_table_lookup_insert_core
    import chtl_pkg::*;
#(
    parameter int BUCKETS    = 11,
    parameter int POOL_NODES = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic [KEY_W-1:0]    key,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                found,
    output logic [BUCKET_W-1:0] bucket,
    output logic [PROBE_W-1:0]  probe_count,
    output logic                pool_full
);

    localparam int HA_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NA_W   = $clog2(POOL_NODES);
    localparam int PTR_W  = $clog2(POOL_NODES + 1);
    localparam int NODE_W = KEY_W + PTR_W;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MOD    = 3'd2;
    localparam logic [2:0] ST_HWAIT  = 3'd3;
    localparam logic [2:0] ST_NODE   = 3'd4;
    localparam logic [2:0] ST_NWAIT  = 3'd5;
    localparam logic [2:0] ST_INSERT = 3'd6;

    logic [2:0]         state_reg,  state_next;
    logic               kind_reg,   kind_next;
    logic [KEY_W-1:0]   key_reg,    key_next;
    logic [HA_W-1:0]    bucket_reg, bucket_next;
    logic [PTR_W-1:0]   head_reg,   head_next;
    logic [PTR_W-1:0]   ptr_reg,    ptr_next;
    logic [PTR_W-1:0]   cnt_reg,    cnt_next;
    logic [PTR_W-1:0]   used_reg,   used_next;
    logic [HA_W-1:0]    clr_reg,    clr_next;
    logic               ovld_reg,   ovld_next;
    logic               found_reg,  found_next;
    logic [PROBE_W-1:0] probe_reg,  probe_next;
    logic               full_reg,   full_next;

    logic               in_xfer;
    logic               out_xfer;
    logic               mod_start;
    logic               mod_done;
    logic [HA_W-1:0]    mod_rem;

    logic               head_we;
    logic [HA_W-1:0]    head_waddr;
    logic [PTR_W-1:0]   head_wdata;
    logic               head_re;
    logic [HA_W-1:0]    head_raddr;
    logic [PTR_W-1:0]   head_rdata;

    logic               node_we;
    logic               node_re;
    logic [NA_W-1:0]    node_raddr;
    logic [NODE_W-1:0]  node_rdata;
    logic [KEY_W-1:0]   node_key;
    logic [PTR_W-1:0]   node_next;

    assign in_stall  = !((state_reg == ST_IDLE) && (!ovld_reg || !out_stall));
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = ovld_reg && !out_stall;
    assign node_key  = node_rdata[NODE_W-1 -: KEY_W];
    assign node_next = node_rdata[PTR_W-1:0];

    chtl_mod_unit #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .key   (key),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    chtl_ram #(
        .WIDTH (PTR_W),
        .DEPTH (BUCKETS)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (head_re),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    chtl_ram #(
        .WIDTH (NODE_W),
        .DEPTH (POOL_NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (NA_W'(used_reg)),
        .wdata ({key_reg, head_reg}),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        key_next    = key_reg;
        bucket_next = bucket_reg;
        head_next   = head_reg;
        ptr_next    = ptr_reg;
        cnt_next    = cnt_reg;
        used_next   = used_reg;
        clr_next    = clr_reg;
        ovld_next   = ovld_reg && !out_xfer;
        found_next  = found_reg;
        probe_next  = probe_reg;
        full_next   = full_reg;

        mod_start   = 1'b0;
        head_we     = 1'b0;
        head_waddr  = bucket_reg;
        head_wdata  = used_reg + PTR_W'(1);
        head_re     = 1'b0;
        head_raddr  = mod_rem;
        node_we     = 1'b0;
        node_re     = 1'b0;
        node_raddr  = NA_W'(ptr_reg - PTR_W'(1));

        case (state_reg)
            ST_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                head_wdata = '0;
                if (clr_reg == HA_W'(BUCKETS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + HA_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    kind_next  = kind;
                    key_next   = key;
                    cnt_next   = '0;
                    mod_start  = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    bucket_next = mod_rem;
                    head_re     = 1'b1;
                    state_next  = ST_HWAIT;
                end
            end
            ST_HWAIT:
            begin
                head_next  = head_rdata;
                ptr_next   = head_rdata;
                state_next = kind_reg ? ST_NODE : ST_INSERT;
            end
            ST_NODE:
            begin
                if (ptr_reg == '0)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    node_re    = 1'b1;
                    cnt_next   = cnt_reg + PTR_W'(1);
                    state_next = ST_NWAIT;
                end
            end
            ST_NWAIT:
            begin
                if (node_key == key_reg)
                begin
                    found_next = 1'b1;
                    probe_next = PROBE_W'(cnt_reg);
                    full_next  = 1'b0;
                    ovld_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next   = node_next;
                    state_next = ST_NODE;
                end
            end
            ST_INSERT:
            begin
                found_next = 1'b0;
                probe_next = '0;
                ovld_next  = 1'b1;
                state_next = ST_IDLE;
                if (used_reg == PTR_W'(POOL_NODES))
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    full_next = 1'b0;
                    node_we   = 1'b1;
                    head_we   = 1'b1;
                    used_next = used_reg + PTR_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            kind_reg   <= 1'b0;
            key_reg    <= '0;
            bucket_reg <= '0;
            head_reg   <= '0;
            ptr_reg    <= '0;
            cnt_reg    <= '0;
            used_reg   <= '0;
            clr_reg    <= '0;
            ovld_reg   <= 1'b0;
            found_reg  <= 1'b0;
            probe_reg  <= '0;
            full_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            key_reg    <= key_next;
            bucket_reg <= bucket_next;
            head_reg   <= head_next;
            ptr_reg    <= ptr_next;
            cnt_reg    <= cnt_next;
            used_reg   <= used_next;
            clr_reg    <= clr_next;
            ovld_reg   <= ovld_next;
            found_reg  <= found_next;
            probe_reg  <= probe_next;
            full_reg   <= full_next;
        end
    end

    assign out_valid   = ovld_reg;
    assign found       = found_reg;
    assign bucket      = BUCKET_W'(bucket_reg);
    assign probe_count = probe_reg;
    assign pool_full   = full_reg;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chained hash table core. A queue of insert and
// lookup requests is driven through the input channel while a local model of
// the bucket chains and the node pool predicts every result; the monitor
// compares each output transfer field by field. The request mix drives the
// pool to exhaustion and walks long chains on lookup hits.
// ----------------------------------------------------------------------------
module tb_top;
    import chtl_pkg::*;

    localparam int unsigned TABLE_BUCKETS  = 11;
    localparam int unsigned POOL_SIZE      = 1024;
    localparam logic        KIND_INSERT    = 1'b0;
    localparam logic        KIND_LOOKUP    = 1'b1;
    localparam logic [KEY_W-1:0] KEY_MAX   = {KEY_W{1'b1}};
    localparam int          RANDOM_ITEMS   = 1140;
    localparam int          HOLD_AT        = 200;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          DRAIN_CYCLES   = 60;
    localparam int          WATCHDOG_LIMIT = 8000;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
    } table_req_t;

    typedef struct packed {
        logic                found;
        logic [BUCKET_W-1:0] bucket;
        logic [PROBE_W-1:0]  probe_count;
        logic                pool_full;
    } table_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                kind = 1'b0;
    logic [KEY_W-1:0]    key = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                found;
    logic [BUCKET_W-1:0] bucket;
    logic [PROBE_W-1:0]  probe_count;
    logic                pool_full;

    // model of the table
    int unsigned         chain_head [TABLE_BUCKETS];
    logic [KEY_W-1:0]    node_key_of [POOL_SIZE];
    int unsigned         node_next_of [POOL_SIZE];
    int unsigned         nodes_taken = 0;

    table_req_t          req_queue [$];
    table_result_t       pending_results [$];
    table_req_t          next_req;
    table_result_t       want;

    // request generator bookkeeping
    bit                  key_seen [logic [KEY_W-1:0]];
    logic [KEY_W-1:0]    known_keys [$];
    int unsigned         gen_used = 0;

    int                  total_items = 0;
    int                  items_sent = 0;
    int                  errors = 0;
    int                  hits_seen = 0;
    int                  drops_seen = 0;
    int unsigned         deepest_walk = 0;
    int                  hold_left = 0;
    bit                  hold_done = 1'b0;
    int                  quiet_cycles = 0;

    chained_hash_table_lookup_insert_core #(
        .BUCKETS    (TABLE_BUCKETS),
        .POOL_NODES (POOL_SIZE)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .key         (key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .bucket      (bucket),
        .probe_count (probe_count),
        .pool_full   (pool_full)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic table_result_t lookup_or_insert(input logic k, input logic [KEY_W-1:0] kv);
        table_result_t r;
        int unsigned   b;
        int unsigned   p;
        int unsigned   visits;
        r = '0;
        b = kv % TABLE_BUCKETS;
        if (k == KIND_LOOKUP)
        begin
            p = chain_head[b];
            visits = 0;
            while (p != 0 && !r.found && visits < POOL_SIZE)
            begin
                visits++;
                if (node_key_of[p-1] == kv)
                begin
                    r.found = 1'b1;
                    r.probe_count = visits[PROBE_W-1:0];
                end
                else
                    p = node_next_of[p-1];
            end
        end
        if (!r.found)
        begin
            if (nodes_taken >= POOL_SIZE)
                r.pool_full = 1'b1;
            else
            begin
                node_key_of[nodes_taken] = kv;
                node_next_of[nodes_taken] = chain_head[b];
                chain_head[b] = nodes_taken + 1;
                nodes_taken++;
            end
        end
        r.bucket = b[BUCKET_W-1:0];
        return r;
    endfunction

    function automatic int unsigned idle_share(input bit is_sender);
        int third;
        third = total_items / 3;
        if (items_sent < third)
            return is_sender ? 25 : 48;
        else if (items_sent < 2 * third)
            return is_sender ? 48 : 25;
        return 0;
    endfunction

    task automatic queue_req(input logic k, input logic [KEY_W-1:0] kv);
        table_req_t r;
        r.kind = k;
        r.key = kv;
        req_queue.push_back(r);
        if ((k == KIND_INSERT || !key_seen.exists(kv)) && gen_used < POOL_SIZE)
        begin
            gen_used++;
            if (!key_seen.exists(kv))
            begin
                key_seen[kv] = 1'b1;
                known_keys.push_back(kv);
            end
        end
    endtask

    // request source
    initial
    begin
        int unsigned      sel;
        logic [KEY_W-1:0] fresh;
        foreach (chain_head[i])
            chain_head[i] = 0;

        queue_req(KIND_LOOKUP, '0);
        queue_req(KIND_LOOKUP, '0);
        queue_req(KIND_INSERT, '0);
        queue_req(KIND_LOOKUP, '0);
        queue_req(KIND_INSERT, 31'd11);
        queue_req(KIND_LOOKUP, '0);
        queue_req(KIND_LOOKUP, 31'd11);
        queue_req(KIND_INSERT, KEY_MAX);
        queue_req(KIND_LOOKUP, KEY_MAX);
        queue_req(KIND_LOOKUP, KEY_MAX - 31'd11);
        queue_req(KIND_INSERT, 31'd10);
        queue_req(KIND_LOOKUP, 31'd21);
        queue_req(KIND_LOOKUP, 31'd10);
        queue_req(KIND_INSERT, 31'h2AAA_AAAA);
        queue_req(KIND_INSERT, 31'h5555_5555);
        queue_req(KIND_LOOKUP, 31'h2AAA_AAAA);
        queue_req(KIND_LOOKUP, 31'h5555_5555);

        // fill the pool with a few hits mixed in, then mostly deep lookups
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            sel = $urandom_range(99);
            fresh = ($urandom_range(9) == 0) ? KEY_W'($urandom_range(60))
                                              : KEY_W'($urandom);
            if (gen_used < POOL_SIZE)
            begin
                if (sel < 6)
                    queue_req(KIND_LOOKUP, known_keys[$urandom_range(known_keys.size() - 1)]);
                else if (sel < 28)
                    queue_req(KIND_LOOKUP, fresh);
                else if (sel < 34)
                    queue_req(KIND_INSERT, known_keys[$urandom_range(known_keys.size() - 1)]);
                else
                    queue_req(KIND_INSERT, fresh);
            end
            else
            begin
                if (sel < 70)
                    queue_req(KIND_LOOKUP, known_keys[$urandom_range(known_keys.size() - 1)]);
                else if (sel < 85)
                    queue_req(KIND_LOOKUP, fresh);
                else
                    queue_req(KIND_INSERT, fresh);
            end
        end
        total_items = req_queue.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (items_sent < total_items)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests: %0d lookup hits, deepest chain walk %0d nodes",
                 total_items, hits_seen, deepest_walk);
        $display("Inserts dropped with the node pool exhausted: %0d", drops_seen);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind <= KIND_INSERT;
            key <= '0;
            items_sent <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                pending_results.push_back(lookup_or_insert(kind, key));
                items_sent <= items_sent + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (req_queue.size() != 0 && $urandom_range(99) >= idle_share(1'b1))
                begin
                    next_req = req_queue.pop_front();
                    in_valid <= 1'b1;
                    kind <= next_req.kind;
                    key <= next_req.key;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, found);
                        errors++;
                    end
                    if (bucket !== want.bucket)
                    begin
                        $error("bucket: expected %0d, got %0d", want.bucket, bucket);
                        errors++;
                    end
                    if (probe_count !== want.probe_count)
                    begin
                        $error("probe_count: expected %0d, got %0d",
                               want.probe_count, probe_count);
                        errors++;
                    end
                    if (pool_full !== want.pool_full)
                    begin
                        $error("pool_full: expected %0d, got %0d", want.pool_full, pool_full);
                        errors++;
                    end
                    if (want.found)
                        hits_seen++;
                    if (want.pool_full)
                        drops_seen++;
                    if (want.probe_count > deepest_walk)
                        deepest_walk = want.probe_count;
                end
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && items_sent >= HOLD_AT)
            begin
                out_stall <= 1'b1;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < idle_share(1'b0));
        end
    end

    // no transfer on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

FILE: files.f
src/chtl_pkg.sv
src/chtl_ram.sv
src/chtl_mod_unit.sv
src/chained_hash_table_lookup_insert_core.sv
verif/tb_top.sv
